FILE: rtl/core/msps_pkg.sv
// Shared types and constants for the multiplexed servo pulse sequencer.
package msps_pkg;

  localparam int unsigned WIDTH_W = 16;

  typedef logic [WIDTH_W-1:0] width_t;
  typedef logic [1:0]         reg_idx_t;

  localparam reg_idx_t REG_PERIOD = 2'd0;
  localparam reg_idx_t REG_MIN    = 2'd1;
  localparam reg_idx_t REG_MAX    = 2'd2;

  localparam width_t PERIOD_RST = 16'd20000;
  localparam width_t MIN_RST    = 16'd5;
  localparam width_t MAX_RST    = 16'd5000;
  localparam width_t WIDTH_SAT  = 16'hFFFF;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load_ticks;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic load_req;
  } sts_t;

  typedef struct packed {
    logic     we;
    reg_idx_t idx;
    width_t   data;
  } cfg_wr_t;

endpackage

FILE: rtl/core/msps_ctrl.sv
// Controller state machine: sequences one transaction through execute and emit.
module msps_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic          out_tready,
  output logic          out_tvalid,
  input  msps_pkg::sts_t sts,
  output msps_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   load_pend_r, load_pend_nxt;
  logic   in_acc;

  assign in_tready  = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_acc     = in_tready && in_tvalid;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    load_pend_nxt  = load_pend_r;
    cmd            = '0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        cmd.capture = in_acc;
        if (in_acc) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec      = 1'b1;
        load_pend_nxt = sts.load_req;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.load_ticks = load_pend_r;
        cmd.emit       = 1'b1;
        out_valid_nxt  = 1'b1;
        load_pend_nxt  = 1'b0;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      load_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      load_pend_r <= load_pend_nxt;
    end
  end

endmodule

FILE: rtl/core/msps_dp.sv
// Datapath: slot widths, configuration registers, slot counter and result register.
module msps_dp #(
  parameter int CHANNELS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  msps_pkg::cmd_t     cmd,
  output msps_pkg::sts_t     sts,
  input  msps_pkg::cfg_wr_t  cfg_wr,
  input  msps_pkg::reg_idx_t cfg_rd_idx,
  output logic [31:0]        cfg_rdata,
  input  logic               in_func,
  input  logic [1:0]         in_channel,
  input  logic [15:0]        in_width,
  output logic [3:0]         out_pins,
  output logic               out_running,
  output logic [2:0]         out_active_slot,
  output logic [15:0]        out_gap_ticks
);

  localparam int SW = (CHANNELS + 1 > 1) ? $clog2(CHANNELS + 1) : 1;
  localparam logic [SW-1:0] COMP_IDX = SW'(CHANNELS);

  // Stored state.
  msps_pkg::width_t slot_w_r [CHANNELS+1];
  msps_pkg::width_t slot_w_nxt [CHANNELS+1];
  msps_pkg::width_t period_r, period_nxt;
  msps_pkg::width_t min_r, min_nxt;
  msps_pkg::width_t max_r, max_nxt;
  msps_pkg::width_t sum_r, sum_nxt;
  msps_pkg::width_t ticks_r, ticks_nxt;
  logic [SW-1:0]    cur_r, cur_nxt;
  logic             run_r, run_nxt;

  // Captured item.
  logic             func_r;
  logic [1:0]       chan_r;
  msps_pkg::width_t req_r;

  // Result register.
  logic [3:0]       pins_r;
  logic             orun_r;
  logic [2:0]       oslot_r;
  msps_pkg::width_t ogap_r;

  // Shared read port over the slot widths.
  logic [SW-1:0]    rd_addr;
  msps_pkg::width_t rd_data;
  logic [SW-1:0]    chan_idx;
  logic             chan_ok;

  // Set arithmetic.
  logic [16:0]      avail;
  logic [16:0]      comp_full;
  msps_pkg::width_t req_clamp;
  msps_pkg::width_t comp_new;
  msps_pkg::width_t sum_new;

  // Next nonzero slot search.
  logic [CHANNELS:0] nz;
  logic              found;
  logic [SW-1:0]     nxt_slot;
  int                s;

  function automatic logic [4:0] in_channel_ext(input logic [1:0] c);
    in_channel_ext = {3'b000, c};
  endfunction

  assign chan_idx = SW'(in_channel_ext(chan_r));
  assign chan_ok  = (int'(chan_r) < CHANNELS);
  assign rd_addr  = cmd.exec ? chan_idx : cur_r;

  always_comb begin
    rd_data = '0;
    for (int i = 0; i <= CHANNELS; i++) begin
      if (rd_addr == SW'(i)) begin
        rd_data = slot_w_r[i];
      end
    end
  end

  always_comb begin
    req_clamp = req_r;
    avail     = {1'b0, slot_w_r[CHANNELS]} + {1'b0, rd_data};
    if (req_clamp > max_r) begin
      req_clamp = max_r;
    end
    if ({1'b0, req_clamp} > avail) begin
      req_clamp = avail[15:0];
    end
    if (req_clamp < min_r) begin
      req_clamp = '0;
    end
    comp_full = avail - {1'b0, req_clamp};
    comp_new  = comp_full[16] ? msps_pkg::WIDTH_SAT : comp_full[15:0];
    sum_new   = sum_r - rd_data + req_clamp;
  end

  always_comb begin
    for (int i = 0; i <= CHANNELS; i++) begin
      nz[i] = (slot_w_r[i] != '0);
    end
    found    = 1'b0;
    nxt_slot = COMP_IDX;
    s        = 0;
    // Nearest slot below the current one wins, wrapping to the gap slot.
    for (int d = CHANNELS + 1; d >= 1; d--) begin
      if (int'(cur_r) >= d) begin
        s = int'(cur_r) - d;
      end else begin
        s = int'(cur_r) + CHANNELS + 1 - d;
      end
      if (nz[SW'(s)]) begin
        found    = 1'b1;
        nxt_slot = SW'(s);
      end
    end
  end

  always_comb begin
    for (int i = 0; i <= CHANNELS; i++) begin
      slot_w_nxt[i] = slot_w_r[i];
    end
    period_nxt   = period_r;
    min_nxt      = min_r;
    max_nxt      = max_r;
    sum_nxt      = sum_r;
    ticks_nxt    = ticks_r;
    cur_nxt      = cur_r;
    run_nxt      = run_r;
    sts.load_req = 1'b0;

    if (cfg_wr.we) begin
      unique case (cfg_wr.idx)
        msps_pkg::REG_PERIOD: begin
          period_nxt = cfg_wr.data;
          slot_w_nxt[CHANNELS] = (cfg_wr.data > sum_r) ? (cfg_wr.data - sum_r) : '0;
        end
        msps_pkg::REG_MIN: min_nxt = cfg_wr.data;
        msps_pkg::REG_MAX: max_nxt = cfg_wr.data;
        default: ;
      endcase
    end else if (cmd.exec) begin
      if (func_r) begin
        if (chan_ok) begin
          for (int i = 0; i < CHANNELS; i++) begin
            if (chan_idx == SW'(i)) begin
              slot_w_nxt[i] = req_clamp;
            end
          end
          slot_w_nxt[CHANNELS] = comp_new;
          sum_nxt              = sum_new;
          if (!run_r && (sum_new != '0)) begin
            run_nxt   = 1'b1;
            cur_nxt   = COMP_IDX;
            ticks_nxt = comp_new;
          end else if (run_r && (sum_new == '0)) begin
            run_nxt   = 1'b0;
            ticks_nxt = '0;
          end
        end
      end else if (run_r) begin
        if (ticks_r <= 16'd1) begin
          ticks_nxt = '0;
          cur_nxt   = nxt_slot;
          // The new slot's width is fetched on the next cycle.
          sts.load_req = found;
        end else begin
          ticks_nxt = ticks_r - 16'd1;
        end
      end
    end else if (cmd.load_ticks) begin
      ticks_nxt = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        slot_w_r[i] <= '0;
      end
      slot_w_r[CHANNELS] <= msps_pkg::PERIOD_RST;
      period_r           <= msps_pkg::PERIOD_RST;
      min_r              <= msps_pkg::MIN_RST;
      max_r              <= msps_pkg::MAX_RST;
      sum_r              <= '0;
      ticks_r            <= '0;
      cur_r              <= COMP_IDX;
      run_r              <= 1'b0;
    end else begin
      for (int i = 0; i <= CHANNELS; i++) begin
        slot_w_r[i] <= slot_w_nxt[i];
      end
      period_r <= period_nxt;
      min_r    <= min_nxt;
      max_r    <= max_nxt;
      sum_r    <= sum_nxt;
      ticks_r  <= ticks_nxt;
      cur_r    <= cur_nxt;
      run_r    <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      chan_r <= in_channel;
      req_r  <= in_width;
    end
    if (cmd.emit) begin
      for (int b = 0; b < 4; b++) begin
        pins_r[b] <= run_r && (b < CHANNELS) && (int'(cur_r) == b);
      end
      orun_r  <= run_r;
      oslot_r <= 3'(int'(cur_r));
      ogap_r  <= slot_w_r[CHANNELS];
    end
  end

  always_comb begin
    unique case (cfg_rd_idx)
      msps_pkg::REG_PERIOD: cfg_rdata = {16'h0000, period_r};
      msps_pkg::REG_MIN:    cfg_rdata = {16'h0000, min_r};
      msps_pkg::REG_MAX:    cfg_rdata = {16'h0000, max_r};
      default:              cfg_rdata = '0;
    endcase
  end

  assign out_pins        = pins_r;
  assign out_running     = orun_r;
  assign out_active_slot = oslot_r;
  assign out_gap_ticks   = ogap_r;

endmodule

FILE: rtl/core/multiplexed_servo_pulse_sequencer.sv
// Top level of the multiplexed servo pulse sequencer: ports, controller and datapath.
//
// Usage: each input transaction is either a one-microsecond tick (in_tuser = 0) or a
// pulse-width update for one channel (in_tuser = 1, channel and width in in_tdata).
// Every input transaction yields exactly one output transaction with the pin pattern,
// the running flag, the active slot and the current gap (complement) width.
// A new input transaction is accepted only after the previous one has been emitted;
// the controller walks each item through capture, execute and emit, and the emit step
// also reloads the slot counter, once the slot has advanced, from the single read port
// on the slot-width registers.
// The next input is accepted in the same cycle as the previous result is taken, so a
// receiver that keeps out_tready high does not stall the input.
// When the receiver stalls, the result is held in the output register and in_tready
// stays low until it is taken; nothing is lost or repeated.
// Reset (synchronous, active low) sets the period to 20000, the minimum pulse to 5,
// the maximum pulse to 5000, all channel widths to zero, the gap to the full period
// and stops the sequencer. The user must write registers through the APB-style port
// only while no transaction is in flight (the block does not enforce this); pready is tied high.
module multiplexed_servo_pulse_sequencer #(
  parameter int CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [1:0] channel, [17:2] width, [23:18] zero
  input  logic [0:0]  in_tuser,   // [0] func: 0 tick, 1 set width
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [3:0] pins, [4] running, [7:5] active_slot,
                                  // [23:8] gap_ticks
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  msps_pkg::cmd_t    cmd;
  msps_pkg::sts_t    sts;
  msps_pkg::cfg_wr_t cfg_wr;

  logic [3:0]  pins;
  logic        running;
  logic [2:0]  active_slot;
  logic [15:0] gap_ticks;

  assign cfg_pready  = 1'b1;
  assign cfg_wr.we   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_wr.idx  = cfg_paddr[3:2];
  assign cfg_wr.data = cfg_pwdata[15:0];

  msps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .sts        (sts),
    .cmd        (cmd)
  );

  msps_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_wr          (cfg_wr),
    .cfg_rd_idx      (cfg_paddr[3:2]),
    .cfg_rdata       (cfg_prdata),
    .in_func         (in_tuser[0]),
    .in_channel      (in_tdata[1:0]),
    .in_width        (in_tdata[17:2]),
    .out_pins        (pins),
    .out_running     (running),
    .out_active_slot (active_slot),
    .out_gap_ticks   (gap_ticks)
  );

  assign out_tdata = {gap_ticks, active_slot, running, pins};

  // Only one transaction is in flight, so an accept cannot follow another directly.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a transaction is in flight");

  // Each accepted transaction produces its result, registered out of the emit state.
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> ##3 out_tvalid)
    else $error("result missing three cycles after accept");

  // At most one pin is driven at a time.
  a_pins_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0(out_tdata[3:0]))
    else $error("more than one pin high");

  // A stopped sequencer drives no pins.
  a_stopped_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[4]) |-> (out_tdata[3:0] == 4'b0000))
    else $error("pin high while stopped");

endmodule
